### hw/rtl/h2r_pkg.sv
package h2r_pkg;

    // Field widths of the color transactions.
    localparam int HUE_W  = 17;
    localparam int BYTE_W = 8;

    // Hue scaling: one degree is split into 2**HUE_FRAC_BITS steps.
    localparam int HUE_FRAC_BITS = 6;
    localparam int SECT_DEG      = 60;
    localparam int SECT_LEN      = SECT_DEG << HUE_FRAC_BITS;
    localparam int PERIOD        = 6 * SECT_LEN;

    // Whole periods added to the signed hue so that every code turns non-negative.
    localparam int HUE_OFS = ((2 ** (HUE_W - 1) + PERIOD - 1) / PERIOD) * PERIOD;
    localparam int HP_W    = 18;
    localparam int COARSE_W = HP_W - HUE_FRAC_BITS;
    localparam int POS_W   = 13;

    // Reciprocal of the sector width in whole degrees, exact for every coarse hue.
    localparam int RECIP_DEG    = 2185;
    localparam int RECIP_DEG_SH = 17;
    localparam int KSECT_W      = 6;

    // Reciprocal of six, exact for a sector count below 36.
    localparam int RECIP_SIX    = 43;
    localparam int RECIP_SIX_SH = 8;

    // Chroma and channel numerator widths.
    localparam int FULL_SCALE = 255;
    localparam int C2_W   = 16;
    localparam int BQ_W   = 17;
    localparam int PROD_W = 29;
    localparam int NUM_W  = 30;

    // The channel numerator is divided by 2 * 255 * SECT_LEN = 2**DIV_SH * DIV_K.
    localparam int DIV_SH       = 9;
    localparam int V_W          = NUM_W - DIV_SH;
    localparam int DIV_K        = (2 * FULL_SCALE * SECT_LEN) >> DIV_SH;
    localparam int DIV_RECIP    = 1122856;
    localparam int DIV_RECIP_SH = 32;
    localparam int Q0_W         = 10;

    // Number of register stages from input to output.
    localparam int STAGES = 7;

    // Sixty-degree hue sectors.
    typedef enum logic [2:0] {
        SEC_RED_YEL,
        SEC_YEL_GRN,
        SEC_GRN_CYN,
        SEC_CYN_BLU,
        SEC_BLU_MAG,
        SEC_MAG_RED
    } t_sector;

endpackage

### hw/rtl/h2r_ifs.sv
// Input channel: one HSL color and its alpha per transaction.
interface h2r_in_if;
    logic                valid;
    logic                ready;
    logic signed [16:0]  hue_angle;
    logic [7:0]          sat_level;
    logic [7:0]          light_level;
    logic [7:0]          alpha_in;

    modport source (output valid, hue_angle, sat_level, light_level, alpha_in,
                    input ready);
    modport sink (input valid, hue_angle, sat_level, light_level, alpha_in,
                  output ready);
endinterface

// Output channel: one RGB color and its alpha per transaction.
interface h2r_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;

    modport source (output valid, red_out, green_out, blue_out, alpha_out,
                    input ready);
    modport sink (input valid, red_out, green_out, blue_out, alpha_out,
                  output ready);
endinterface

### hw/rtl/h2r_hue_sector.sv
module h2r_hue_sector
    import h2r_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [HUE_W-1:0] i_hue,
    output t_sector                 o_sector,
    output logic [POS_W-1:0]        o_pos
);

    logic [HP_W:0]             w_sum;
    logic [HP_W-1:0]           r_hp;
    logic [COARSE_W-1:0]       w_coarse;
    logic [22:0]               w_kprod;
    logic [KSECT_W-1:0]        r_ksect;
    logic [COARSE_W-1:0]       r_coarse;
    logic [HUE_FRAC_BITS-1:0]  r_frac;
    logic [COARSE_W-1:0]       w_kdeg;
    logic [COARSE_W-1:0]       w_rem;
    logic [COARSE_W-1:0]       w_k43;
    logic [KSECT_W-1:0]        w_turns;
    logic [KSECT_W-1:0]        w_secn;
    logic [POS_W-1:0]          w_pos_raw;
    logic [POS_W-1:0]          n_pos;
    t_sector                   r_sector;
    logic [POS_W-1:0]          r_pos;

    // Stage one: shift the signed hue up by whole periods into a non-negative range.
    assign w_sum = {{(HP_W + 1 - HUE_W){i_hue[HUE_W-1]}}, i_hue} + (HP_W + 1)'(HUE_OFS);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hp <= w_sum[HP_W-1:0];
        end
    end

    // Stage two: whole degrees divided by the sector width, through a reciprocal.
    assign w_coarse = r_hp[HP_W-1:HUE_FRAC_BITS];
    assign w_kprod  = 23'(w_coarse) * 23'(RECIP_DEG);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ksect  <= w_kprod[RECIP_DEG_SH +: KSECT_W];
            r_coarse <= w_coarse;
            r_frac   <= r_hp[HUE_FRAC_BITS-1:0];
        end
    end

    // Stage three: position inside the sector, and the sector count folded modulo six.
    assign w_kdeg    = COARSE_W'(r_ksect) * COARSE_W'(SECT_DEG);
    assign w_rem     = r_coarse - w_kdeg;
    assign w_pos_raw = POS_W'({w_rem[KSECT_W-1:0], r_frac});
    assign w_k43     = COARSE_W'(r_ksect) * COARSE_W'(RECIP_SIX);
    assign w_turns   = KSECT_W'(w_k43[COARSE_W-1:RECIP_SIX_SH]);
    assign w_secn    = r_ksect - KSECT_W'(w_turns * KSECT_W'(6));

    // Odd sectors measure the position from the far edge.
    always_comb begin
        if (w_secn[0]) begin
            n_pos = POS_W'(SECT_LEN) - w_pos_raw;
        end else begin
            n_pos = w_pos_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sector <= t_sector'(w_secn[2:0]);
            r_pos    <= n_pos;
        end
    end

    assign o_sector = r_sector;
    assign o_pos    = r_pos;

endmodule

### hw/rtl/h2r_byte_div.sv
module h2r_byte_div
    import h2r_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [V_W-1:0]    i_v,
    output logic [BYTE_W-1:0] o_byte
);

    logic [2*V_W-1:0]  w_prod;
    logic [Q0_W-1:0]   r_q0;
    logic [V_W-1:0]    r_v;
    logic [V_W-1:0]    w_back;
    logic [V_W-1:0]    w_rem;
    logic [Q0_W-1:0]   w_q;
    logic [BYTE_W-1:0] r_byte;

    // First stage: quotient estimate from the reciprocal, at most one too small.
    assign w_prod = (2 * V_W)'(i_v) * (2 * V_W)'(DIV_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q0 <= w_prod[DIV_RECIP_SH +: Q0_W];
            r_v  <= i_v;
        end
    end

    // Second stage: correct the estimate by one remainder check and clamp to a byte.
    assign w_back = V_W'(r_q0) * V_W'(DIV_K);
    assign w_rem  = r_v - w_back;
    assign w_q    = r_q0 + Q0_W'(w_rem >= V_W'(DIV_K));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_q > Q0_W'(FULL_SCALE)) begin
                r_byte <= BYTE_W'(FULL_SCALE);
            end else begin
                r_byte <= w_q[BYTE_W-1:0];
            end
        end
    end

    assign o_byte = r_byte;

endmodule

### hw/rtl/hsl_to_rgb_converter_core.sv
// Channel   Direction  Handshake     Payload
// i_pix     in         valid/ready   hue_angle, sat_level, light_level, alpha_in
// o_pix     out        valid/ready   red_out, green_out, blue_out, alpha_out
//
// A color can enter every cycle while the output is not held; throughput is then one per clock.
// The depth is set by the hue divider (three stages), the chroma products and channel
// sum (two stages) and the byte divider with its correction (two stages).
// Reset clears only the stage valid bits; data registers hold whatever they last held.
// When the output is held, every stage freezes together, so nothing is dropped or repeated.
module hsl_to_rgb_converter_core
    import h2r_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    h2r_in_if.sink     i_pix,
    h2r_out_if.source  o_pix
);

    logic                  w_en;
    logic [STAGES-1:0]     r_vld;
    logic [BYTE_W-1:0]     r_alpha [STAGES];

    logic [BYTE_W-1:0]     w_dist;
    logic [C2_W-1:0]       w_c2;
    logic [C2_W-1:0]       r1_c2;
    logic [BYTE_W-1:0]     r1_light;
    logic [BQ_W-1:0]       w_bq;
    logic [C2_W-1:0]       r2_c2;
    logic [BQ_W-1:0]       r2_bq;
    logic [C2_W-1:0]       r3_c2;
    logic [BQ_W-1:0]       r3_bq;

    t_sector               w_sector;
    logic [POS_W-1:0]      w_pos;

    logic [PROD_W-1:0]     r4_cn;
    logic [PROD_W-1:0]     r4_xn;
    logic [PROD_W-1:0]     r4_base;
    t_sector               r4_sector;

    logic [PROD_W-1:0]     w_sel_r;
    logic [PROD_W-1:0]     w_sel_g;
    logic [PROD_W-1:0]     w_sel_b;
    logic [NUM_W-1:0]      w_num_r;
    logic [NUM_W-1:0]      w_num_g;
    logic [NUM_W-1:0]      w_num_b;
    logic [V_W-1:0]        r5_v_r;
    logic [V_W-1:0]        r5_v_g;
    logic [V_W-1:0]        r5_v_b;

    // The whole pipeline advances unless a finished result is being held.
    assign w_en        = !r_vld[STAGES-1] || o_pix.ready;
    assign i_pix.ready = w_en;

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[STAGES-2:0], i_pix.valid};
        end
    end

    // Alpha rides along the stages unchanged.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_alpha[0] <= i_pix.alpha_in;
            for (int k = 1; k < STAGES; k++) begin
                r_alpha[k] <= r_alpha[k-1];
            end
        end
    end

    // Stage one: chroma numerator (255 - |2L - 255|) * S.
    always_comb begin
        if (i_pix.light_level[BYTE_W-1]) begin
            w_dist = BYTE_W'({i_pix.light_level, 1'b0} - 9'(FULL_SCALE));
        end else begin
            w_dist = BYTE_W'(9'(FULL_SCALE) - {i_pix.light_level, 1'b0});
        end
    end

    assign w_c2 = C2_W'(BYTE_W'(FULL_SCALE) - w_dist) * C2_W'(i_pix.sat_level);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_c2    <= w_c2;
            r1_light <= i_pix.light_level;
        end
    end

    // Stage two: lightness term of m plus the rounding half, 510 L + 255 - C2.
    assign w_bq = BQ_W'(r1_light) * BQ_W'(2 * FULL_SCALE) + BQ_W'(FULL_SCALE) - BQ_W'(r1_c2);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_c2 <= r1_c2;
            r2_bq <= w_bq;
        end
    end

    // Stage three: carry chroma alongside the hue sector search.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_c2 <= r2_c2;
            r3_bq <= r2_bq;
        end
    end

    h2r_hue_sector u_sector (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_hue    (i_pix.hue_angle),
        .o_sector (w_sector),
        .o_pos    (w_pos)
    );

    // Stage four: chroma, x and base numerators over 2 * 65025 * sector length.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_cn     <= PROD_W'(r3_c2) * PROD_W'(2 * SECT_LEN);
            r4_xn     <= PROD_W'(r3_c2) * PROD_W'({w_pos, 1'b0});
            r4_base   <= PROD_W'(r3_bq) * PROD_W'(SECT_LEN);
            r4_sector <= w_sector;
        end
    end

    // Stage five: place chroma and x on the channels by sector and add the base.
    always_comb begin
        unique case (r4_sector)
            SEC_RED_YEL: begin
                w_sel_r = r4_cn;
                w_sel_g = r4_xn;
                w_sel_b = '0;
            end
            SEC_YEL_GRN: begin
                w_sel_r = r4_xn;
                w_sel_g = r4_cn;
                w_sel_b = '0;
            end
            SEC_GRN_CYN: begin
                w_sel_r = '0;
                w_sel_g = r4_cn;
                w_sel_b = r4_xn;
            end
            SEC_CYN_BLU: begin
                w_sel_r = '0;
                w_sel_g = r4_xn;
                w_sel_b = r4_cn;
            end
            SEC_BLU_MAG: begin
                w_sel_r = r4_xn;
                w_sel_g = '0;
                w_sel_b = r4_cn;
            end
            default: begin
                w_sel_r = r4_cn;
                w_sel_g = '0;
                w_sel_b = r4_xn;
            end
        endcase
    end

    assign w_num_r = NUM_W'(r4_base) + NUM_W'(w_sel_r);
    assign w_num_g = NUM_W'(r4_base) + NUM_W'(w_sel_g);
    assign w_num_b = NUM_W'(r4_base) + NUM_W'(w_sel_b);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_v_r <= w_num_r[NUM_W-1:DIV_SH];
            r5_v_g <= w_num_g[NUM_W-1:DIV_SH];
            r5_v_b <= w_num_b[NUM_W-1:DIV_SH];
        end
    end

    // Stages six and seven: one divider per channel, the last register drives the output.
    h2r_byte_div u_div_r (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_v    (r5_v_r),
        .o_byte (o_pix.red_out)
    );

    h2r_byte_div u_div_g (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_v    (r5_v_g),
        .o_byte (o_pix.green_out)
    );

    h2r_byte_div u_div_b (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_v    (r5_v_b),
        .o_byte (o_pix.blue_out)
    );

    assign o_pix.valid     = r_vld[STAGES-1];
    assign o_pix.alpha_out = r_alpha[STAGES-1];

    // A held result must block new input.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid && !o_pix.ready |-> !i_pix.ready)
        else $error("input accepted while the output is held");

    // An accepted transaction occupies the first stage on the next cycle.
    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix.valid && i_pix.ready |=> r_vld[0])
        else $error("accepted transaction missing from the first stage");

    // A frozen pipeline keeps every valid bit.
    a_freeze_holds_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("valid bits moved during a stall");

    // The folded sector position never exceeds one sector.
    a_pos_in_sector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> w_pos <= POS_W'(SECT_LEN))
        else $error("sector position out of range");

endmodule
